// ----- sv/stq_pkg.sv -----
// sorted timeout queue: shared types and codes
// used by sorted_timeout_queue; no dependencies
`default_nettype none

package stq_pkg;

  typedef enum logic [2:0] {
    OP_ADD         = 3'd0,
    OP_CHECK       = 3'd1,
    OP_REM_EXACT   = 3'd2,
    OP_REM_COVERED = 3'd3,
    OP_REM_START   = 3'd4,
    OP_FIND        = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] seq_from;
    logic [31:0] seq_to;
    logic [31:0] expiry;
  } entry_t;

endpackage

`default_nettype wire

// ----- sv/stq_ram.sv -----
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module stq_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/sorted_timeout_queue.sv -----
// sorted timeout queue top level: sequencer, scan unit and entry store
// depends on stq_pkg and stq_ram
`default_nettype none

// Usage
//   in_* carries one command transaction: operation, now_time, timeout_sec,
//   range_from, range_to. out_* returns exactly one result transaction per
//   command: status, expired_from, expired_to, removed_count.
//   Entries live in one ram, kept sorted by expiry. Every defined command
//   runs one filter pass over the n stored entries (read, test and, except
//   for a find, compact in place); an add with a free slot follows it with
//   a downward insert pass that shifts later entries up by one. Undefined
//   operation codes skip both passes.
//   Both passes read one entry per cycle through the single ram read port.
//   in_stall is high while a command is being worked on; one command is in
//   flight at a time.
//   The result sits in an output register, so the next command is taken
//   while a result still waits; if out_stall holds, the block finishes the
//   following command and waits before presenting it.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; the ram contents need no clearing.
module sorted_timeout_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_now_time,
  input  wire logic [15:0] in_timeout_sec,
  input  wire logic [31:0] in_range_from,
  input  wire logic [32:0] in_range_to,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_expired_from,
  output logic [31:0]      out_expired_to,
  output logic [4:0]       out_removed_count
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(stq_pkg::entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILT,
    S_INS,
    S_DONE
  } state_t;

  state_t         state_r;
  logic [2:0]     op_r;
  logic [31:0]    now_r;
  logic [31:0]    exp_r;
  logic [31:0]    from_r;
  logic [32:0]    to_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  iss_r;
  logic [CW-1:0]  wr_r;
  logic [AW-1:0]  ev_idx_r;
  logic           pv_r;
  logic           hit_r;
  logic [1:0]     status_r;
  logic [31:0]    exf_r;
  logic [31:0]    ext_r;
  logic [CW-1:0]  removed_r;
  logic           out_valid_r;
  logic [1:0]     out_status_r;
  logic [31:0]    out_exf_r;
  logic [31:0]    out_ext_r;
  logic [CW-1:0]  out_removed_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;
  stq_pkg::entry_t      ev;
  stq_pkg::entry_t      new_entry;
  logic [32:0]          ev_to_ext;
  logic                 pred;
  logic                 first_only;
  logic                 take;
  logic                 drop;
  logic                 issue;
  logic                 pass_end;
  logic                 ins_ge;
  logic                 place;
  logic [CW-1:0]        iss_m1;
  logic [31:0]          rc_ext;

  stq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ev         = stq_pkg::entry_t'(ram_rdata);
    new_entry  = '{seq_from: from_r, seq_to: to_r[31:0], expiry: exp_r};
    ev_to_ext  = {(ev.seq_to < ev.seq_from), ev.seq_to};
    iss_m1     = iss_r - CW'(1);
    first_only = (op_r == stq_pkg::OP_ADD) || (op_r == stq_pkg::OP_REM_EXACT);
    case (op_r)
      stq_pkg::OP_ADD, stq_pkg::OP_REM_EXACT, stq_pkg::OP_FIND: begin
        pred = (ev.seq_from == from_r) && (ev.seq_to == to_r[31:0]);
      end
      stq_pkg::OP_CHECK: begin
        pred = (ev_idx_r == '0) && (ev.expiry <= now_r);
      end
      stq_pkg::OP_REM_COVERED: begin
        pred = (from_r <= ev.seq_from) && (to_r >= ev_to_ext);
      end
      stq_pkg::OP_REM_START: begin
        pred = (ev.seq_from == from_r);
      end
      default: begin
        pred = 1'b0;
      end
    endcase
    take     = pv_r && pred && !(first_only && hit_r);
    drop     = take && (op_r != stq_pkg::OP_FIND);
    ins_ge   = ev.expiry >= exp_r;
    issue    = 1'b0;
    pass_end = 1'b0;
    place    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wr_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = iss_r[AW-1:0];
    case (state_r)
      S_FILT: begin
        issue    = iss_r < cnt_r;
        pass_end = !pv_r && !issue;
        ram_we   = pv_r && !drop && (op_r != stq_pkg::OP_FIND);
      end
      S_INS: begin
        issue     = iss_r != '0;
        ram_raddr = iss_m1[AW-1:0];
        if (pv_r) begin
          ram_we    = 1'b1;
          ram_waddr = ev_idx_r + AW'(1);
          ram_wdata = ins_ge ? ram_rdata : EW'(new_entry);
          place     = !ins_ge;
        end else if (iss_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = EW'(new_entry);
          place     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= in_operation;
            now_r     <= in_now_time;
            exp_r     <= in_now_time + 32'(in_timeout_sec);
            from_r    <= in_range_from;
            to_r      <= in_range_to;
            iss_r     <= '0;
            wr_r      <= '0;
            pv_r      <= 1'b0;
            hit_r     <= 1'b0;
            exf_r     <= '0;
            ext_r     <= '0;
            removed_r <= '0;
            status_r  <= stq_pkg::ST_NONE;
            if (in_operation <= stq_pkg::OP_FIND) begin
              state_r <= S_FILT;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_FILT: begin
          pv_r <= issue;
          if (issue) begin
            iss_r    <= iss_r + CW'(1);
            ev_idx_r <= iss_r[AW-1:0];
          end
          if (take) begin
            hit_r <= 1'b1;
          end
          if (pv_r && !drop && (op_r != stq_pkg::OP_FIND)) begin
            wr_r <= wr_r + CW'(1);
          end
          if (drop && (op_r == stq_pkg::OP_CHECK)) begin
            exf_r <= ev.seq_from;
            ext_r <= ev.seq_to;
          end
          if (pass_end) begin
            if (op_r != stq_pkg::OP_FIND) begin
              cnt_r <= wr_r;
            end
            removed_r <= (op_r == stq_pkg::OP_FIND) ? '0 : cnt_r - wr_r;
            case (op_r)
              stq_pkg::OP_ADD: begin
                if (wr_r >= CW'(QUEUE_DEPTH)) begin
                  status_r <= stq_pkg::ST_FULL;
                  state_r  <= S_DONE;
                end else begin
                  iss_r   <= wr_r;
                  pv_r    <= 1'b0;
                  state_r <= S_INS;
                end
              end
              stq_pkg::OP_REM_COVERED, stq_pkg::OP_REM_START: begin
                status_r <= stq_pkg::ST_OK;
                state_r  <= S_DONE;
              end
              default: begin
                status_r <= hit_r ? stq_pkg::ST_OK : stq_pkg::ST_NONE;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          pv_r <= issue;
          if (issue) begin
            iss_r    <= iss_m1;
            ev_idx_r <= iss_m1[AW-1:0];
          end
          if (place) begin
            cnt_r    <= cnt_r + CW'(1);
            status_r <= stq_pkg::ST_OK;
            pv_r     <= 1'b0;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= status_r;
            out_exf_r     <= exf_r;
            out_ext_r     <= ext_r;
            out_removed_r <= removed_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign rc_ext            = 32'(out_removed_r);
  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_expired_from  = out_exf_r;
  assign out_expired_to    = out_ext_r;
  assign out_removed_count = rc_ext[4:0];

  // queue never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // insertion only starts with a free slot
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (cnt_r < CW'(QUEUE_DEPTH)))
    else $error("insert pass on a full queue");

  // compaction write pointer never overtakes the entry under test
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILT && pv_r) |-> (wr_r <= CW'(ev_idx_r)))
    else $error("compaction write ahead of read");

  // a finished command is presented once the output register is free
  a_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(out_valid_r && out_stall)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented");

endmodule

`default_nettype wire
